>>> design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and constants for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_W        = 16;  // port width of one coordinate
    localparam int OUT_W          = 16;  // port width of one normal component
    localparam int COORD_BITS_DEF = 16;
    localparam int NORM_FRAC_DEF  = 14;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] norm_x;
        logic signed [OUT_W-1:0] norm_y;
        logic signed [OUT_W-1:0] norm_z;
        logic                    degenerate;
    } t_norm_out;

    // per-item control that rides along the root stages
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } t_side;

endpackage

>>> design/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, exact cross product, squared length and the starting
// remainders for the normalizing recurrence. Five register stages.
// ----------------------------------------------------------------------------
module tun_front #(
    parameter int C = 16,
    parameter int F = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  tun_pkg::t_tri_in       i_data,
    output logic [2*(2*(C+1))+1:0] o_s,
    output logic [2:0][2*(2*(C+1))+2*F+6:0] o_r,
    output logic [2:0][2*(2*(C+1))+F+4:0]   o_w,
    output tun_pkg::t_side         o_side
);
    import tun_pkg::*;

    localparam int E    = C + 1;
    localparam int M    = 2 * E;
    localparam int NW   = M + 1;
    localparam int SQ_W = 2 * M;
    localparam int S    = 2 * M + 2;
    localparam int RW   = S + 2 * F + 5;
    localparam int WW   = S + F + 3;

    logic signed [C-1:0] c_ax, c_ay, c_az, c_bx, c_by, c_bz, c_cx, c_cy, c_cz;

    logic signed [E-1:0]  r1_e1 [3];
    logic signed [E-1:0]  r1_e2 [3];
    logic signed [M-1:0]  r2_p  [6];
    logic [M-1:0]         r3_mag [3];
    logic [2:0]           r3_neg;
    logic [SQ_W-1:0]      r4_sq [3];
    logic [2:0]           r4_neg;
    logic [4:0]           r_vld;
    logic [2:0]           r5_neg;
    logic                 r5_degen;
    logic [S-1:0]         r5_s;
    logic [2:0][RW-1:0]   r5_r;
    logic [2:0][WW-1:0]   r5_w;

    logic signed [NW-1:0] n3_n [3];
    logic [S-1:0]         n5_s;

    assign c_ax = C'(i_data.ax);
    assign c_ay = C'(i_data.ay);
    assign c_az = C'(i_data.az);
    assign c_bx = C'(i_data.bx);
    assign c_by = C'(i_data.by);
    assign c_bz = C'(i_data.bz);
    assign c_cx = C'(i_data.cx);
    assign c_cy = C'(i_data.cy);
    assign c_cz = C'(i_data.cz);

    assign n3_n[0] = NW'(r2_p[0]) - NW'(r2_p[1]);
    assign n3_n[1] = NW'(r2_p[2]) - NW'(r2_p[3]);
    assign n3_n[2] = NW'(r2_p[4]) - NW'(r2_p[5]);

    assign n5_s = S'(r4_sq[0]) + S'(r4_sq[1]) + S'(r4_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: edges e1 = b - a, e2 = c - b
            r1_e1[0] <= E'(c_bx) - E'(c_ax);
            r1_e1[1] <= E'(c_by) - E'(c_ay);
            r1_e1[2] <= E'(c_bz) - E'(c_az);
            r1_e2[0] <= E'(c_cx) - E'(c_bx);
            r1_e2[1] <= E'(c_cy) - E'(c_by);
            r1_e2[2] <= E'(c_cz) - E'(c_bz);
            // stage 2: cross product partial products
            r2_p[0] <= M'(r1_e1[1]) * M'(r1_e2[2]);
            r2_p[1] <= M'(r1_e1[2]) * M'(r1_e2[1]);
            r2_p[2] <= M'(r1_e1[2]) * M'(r1_e2[0]);
            r2_p[3] <= M'(r1_e1[0]) * M'(r1_e2[2]);
            r2_p[4] <= M'(r1_e1[0]) * M'(r1_e2[1]);
            r2_p[5] <= M'(r1_e1[1]) * M'(r1_e2[0]);
            // stage 3: sign and magnitude
            for (int k = 0; k < 3; k++) begin
                r3_neg[k] <= n3_n[k][NW-1];
                r3_mag[k] <= n3_n[k][NW-1] ? M'(-n3_n[k]) : M'(n3_n[k]);
            end
            // stage 4: squares
            for (int k = 0; k < 3; k++) begin
                r4_sq[k] <= SQ_W'(r3_mag[k]) * SQ_W'(r3_mag[k]);
            end
            r4_neg <= r3_neg;
            // stage 5: length squared, remainder = 4*m^2*2^2F - s, W = -s
            r5_s     <= n5_s;
            r5_neg   <= r4_neg;
            r5_degen <= (r4_sq[0] == '0) && (r4_sq[1] == '0) && (r4_sq[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r5_r[k] <= (RW'(r4_sq[k]) << (2 * F + 2)) - RW'(n5_s);
                r5_w[k] <= WW'(0) - WW'(n5_s);
            end
        end
    end

    assign o_s          = r5_s;
    assign o_r          = r5_r;
    assign o_w          = r5_w;
    assign o_side.valid = r_vld[4];
    assign o_side.degen = r5_degen;
    assign o_side.neg   = r5_neg;

endmodule

>>> design/tun_root_step.sv
// ----------------------------------------------------------------------------
// tun_root_step
// One result bit of round(m * 2^F / sqrt(s)) for all three components.
// Keeps R = 4 m^2 2^2F - (2q-1)^2 s and W = (2q-1) s up to date by shifts
// and adds only.
// ----------------------------------------------------------------------------
module tun_root_step #(
    parameter int S   = 70,
    parameter int F   = 14,
    parameter int BIT = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [S-1:0]          i_s,
    input  logic [2:0][S+2*F+4:0] i_r,
    input  logic [2:0][S+F+2:0]   i_w,
    input  logic [2:0][F:0]       i_q,
    input  tun_pkg::t_side        i_side,
    output logic [S-1:0]          o_s,
    output logic [2:0][S+2*F+4:0] o_r,
    output logic [2:0][S+F+2:0]   o_w,
    output logic [2:0][F:0]       o_q,
    output tun_pkg::t_side        o_side
);
    import tun_pkg::*;

    localparam int RW = S + 2 * F + 5;
    localparam int WW = S + F + 3;

    logic [RW-1:0]      c_sq_term;
    logic [WW-1:0]      c_w_inc;
    logic [2:0][RW-1:0] c_trial;
    logic [2:0]         c_take;

    logic [S-1:0]         r_s;
    logic [2:0][RW-1:0]   r_r;
    logic [2:0][WW-1:0]   r_w;
    logic [2:0][F:0]      r_q;
    logic                 r_valid;
    logic                 r_degen;
    logic [2:0]           r_neg;

    assign c_sq_term = RW'(i_s) << (2 * BIT + 2);
    assign c_w_inc   = WW'(i_s) << (BIT + 1);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_trial[k] = i_r[k] - (RW'($signed(i_w[k])) << (BIT + 2)) - c_sq_term;
            c_take[k]  = !c_trial[k][RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= i_s;
            r_degen <= i_side.degen;
            r_neg   <= i_side.neg;
            for (int k = 0; k < 3; k++) begin
                r_r[k] <= c_take[k] ? c_trial[k] : i_r[k];
                r_w[k] <= c_take[k] ? i_w[k] + c_w_inc : i_w[k];
                r_q[k] <= i_q[k] | ((F+1)'(c_take[k]) << BIT);
            end
        end
    end

    assign o_s          = r_s;
    assign o_r          = r_r;
    assign o_w          = r_w;
    assign o_q          = r_q;
    assign o_side.valid = r_valid;
    assign o_side.degen = r_degen;
    assign o_side.neg   = r_neg;

endmodule

>>> design/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a triangle, signed fixed point, zero vector and a
// degenerate flag when the cross product vanishes.
// ----------------------------------------------------------------------------
// Pipeline from input transaction to output valid: 5 front stages, one
// root stage per result bit, 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being taken.
// Reset: synchronous active-low clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top #(
    parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tun_pkg::t_tri_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tun_pkg::t_norm_out  o_out_data
);
    import tun_pkg::*;

    localparam int F  = NORM_FRAC_BITS;
    localparam int M  = 2 * (COORD_BITS + 1);
    localparam int S  = 2 * M + 2;
    localparam int RW = S + 2 * F + 5;
    localparam int WW = S + F + 3;
    localparam int QW = F + 1;

    logic en;

    logic [F+1:0][S-1:0]         c_s;
    logic [F+1:0][2:0][RW-1:0]   c_r;
    logic [F+1:0][2:0][WW-1:0]   c_w;
    logic [F+1:0][2:0][QW-1:0]   c_q;
    t_side                       c_side [F+2];

    logic [2:0][OUT_W-1:0] n_norm;
    t_norm_out             r_out_data;
    logic                  r_out_valid;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    tun_front #(
        .C (COORD_BITS),
        .F (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_s     (c_s[0]),
        .o_r     (c_r[0]),
        .o_w     (c_w[0]),
        .o_side  (c_side[0])
    );

    assign c_q[0] = '0;

    for (genvar j = 0; j <= F; j++) begin : g_root
        tun_root_step #(
            .S   (S),
            .F   (F),
            .BIT (F - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_s     (c_s[j]),
            .i_r     (c_r[j]),
            .i_w     (c_w[j]),
            .i_q     (c_q[j]),
            .i_side  (c_side[j]),
            .o_s     (c_s[j+1]),
            .o_r     (c_r[j+1]),
            .o_w     (c_w[j+1]),
            .o_q     (c_q[j+1]),
            .o_side  (c_side[j+1])
        );
    end

    // apply sign, zero the vector when degenerate, keep low OUT_W bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (c_side[F+1].degen) begin
                n_norm[k] = '0;
            end else if (c_side[F+1].neg[k]) begin
                n_norm[k] = OUT_W'((QW+1)'(0) - (QW+1)'(c_q[F+1][k]));
            end else begin
                n_norm[k] = OUT_W'(c_q[F+1][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_side[F+1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data.norm_x     <= n_norm[0];
            r_out_data.norm_y     <= n_norm[1];
            r_out_data.norm_z     <= n_norm[2];
            r_out_data.degenerate <= c_side[F+1].degen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
